[src/clflru_pkg.sv]
// ----------------------------------------------------------------------------
// clflru_pkg
// Shared types and defaults for the clean-first lru victim selector.
// ----------------------------------------------------------------------------
package clflru_pkg;

  localparam int NUM_SETS_DEF  = 64;
  localparam int NUM_WAYS_DEF  = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam int SET_FIELD_W   = 6;
  localparam int WAY_FIELD_W   = 3;
  localparam int DIRTY_FIELD_W = 8;
  localparam int TIME_FIELD_W  = 32;

  typedef enum logic [1:0] {
    REQ_INVALIDATE = 2'd0,
    REQ_TOUCH      = 2'd1,
    REQ_FILL       = 2'd2,
    REQ_QUERY      = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t                  req_type;
    logic [SET_FIELD_W-1:0]     set_index;
    logic [WAY_FIELD_W-1:0]     way_index;
    logic [DIRTY_FIELD_W-1:0]   dirty_mask;
    logic [TIME_FIELD_W-1:0]    current_time;
  } req_t;

  typedef struct packed {
    logic                       victim_valid;
    logic [WAY_FIELD_W-1:0]     victim_way;
    logic                       victim_dirty;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROC
  } state_t;

endpackage

[src/clflru_req_if.sv]
// ----------------------------------------------------------------------------
// clflru_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface clflru_req_if
  import clflru_pkg::*;
  ;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/clflru_rsp_if.sv]
// ----------------------------------------------------------------------------
// clflru_rsp_if
// Response channel: valid/ready handshake carrying one victim result.
// ----------------------------------------------------------------------------
interface clflru_rsp_if
  import clflru_pkg::*;
  ;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/clean_first_lru_victim_select.sv]
// ----------------------------------------------------------------------------
// clean_first_lru_victim_select
// Per-set last-touch timestamps held in a row-wide memory; invalidate, touch
// and fill update one way, a victim query picks the oldest clean way, or the
// oldest way when all are dirty.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          transfer
//  req      in   req_type set_index way_index dirty_mask time     valid & ready
//  rsp      out  victim_valid victim_way victim_dirty             valid & ready
//
//  every request goes through accept + row read, then compare/write back
//  each request reads its set's row (all ways) on one port; a query writes none
//  after reset the memory is cleared one row per cycle, every set in turn,
//  during which req.ready stays low
//  the result sits in an output register; a new request is taken while it
//  waits, and the second stage holds only when that register is still full
// ----------------------------------------------------------------------------
module clean_first_lru_victim_select
  import clflru_pkg::*;
#(
  parameter int NUM_SETS  = NUM_SETS_DEF,
  parameter int NUM_WAYS  = NUM_WAYS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  clflru_req_if.sink   req,
  clflru_rsp_if.source rsp
);

  localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_BITS = $clog2(NUM_WAYS);
  localparam int LEAVES   = 1 << WAY_BITS;
  localparam int ROW_W    = NUM_WAYS * TIME_BITS;
  localparam int DIRTY_W  = (NUM_WAYS > DIRTY_FIELD_W) ? NUM_WAYS : DIRTY_FIELD_W;
  localparam int KEY_W    = TIME_BITS + 1;

  // set_index reduced modulo NUM_SETS, one restoring step per bit
  function automatic logic [SET_BITS-1:0] set_reduce(input logic [SET_FIELD_W-1:0] s);
    logic [SET_FIELD_W:0] r;
    r = '0;
    for (int i = SET_FIELD_W - 1; i >= 0; i--) begin
      r = {r[SET_FIELD_W-1:0], s[i]};
      if (int'(r) >= NUM_SETS) begin
        r = r - (SET_FIELD_W + 1)'(NUM_SETS);
      end
    end
    return SET_BITS'(r);
  endfunction

  // memory
  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [ROW_W-1:0]    rd_row;
  logic                mem_we;
  logic [SET_BITS-1:0] mem_waddr;
  logic [ROW_W-1:0]    mem_wdata;
  logic [SET_BITS-1:0] rd_addr;

  // control
  state_t              state, state_next;
  logic [SET_BITS-1:0] clr_cnt;
  logic                clr_last;
  logic                accept;
  logic                out_free;
  logic                proc_done;

  // request held for the compare/write-back state
  req_t                item;
  logic [SET_BITS-1:0] item_set;

  // output register
  logic                out_valid;
  rsp_t                out_data;
  rsp_t                result;

  // compare / update
  logic [DIRTY_W-1:0]         dirty_ext;
  logic [LEAVES*TIME_BITS-1:0] ts_pad;
  logic [KEY_W-1:0]           node_key [1:2*LEAVES-1];
  logic [WAY_BITS-1:0]        node_way [1:2*LEAVES-1];
  logic                       wr_hit;
  logic [TIME_BITS-1:0]       wr_time;
  logic [ROW_W-1:0]           new_row;

  assign rd_addr  = set_reduce(req.data.set_index);
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign clr_last = (clr_cnt == SET_BITS'(NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_PROC;
      ST_PROC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    req.ready = 1'b0;
    proc_done = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = item_set;
    mem_wdata = new_row;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_PROC: begin
        proc_done = out_free;
        mem_we    = out_free && wr_hit;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= req.data;
      item_set <= rd_addr;
    end
  end

  // clean-first oldest way: key is {dirty, timestamp}, min over a tree,
  // ties resolve to the left (lower) way; padding leaves sit on the right
  assign dirty_ext = DIRTY_W'(item.dirty_mask);
  assign ts_pad    = (LEAVES * TIME_BITS)'(rd_row);

  always_comb begin
    for (int w = 0; w < LEAVES; w++) begin
      if (w < NUM_WAYS) begin
        node_key[LEAVES + w] = {dirty_ext[w], ts_pad[w*TIME_BITS +: TIME_BITS]};
      end else begin
        node_key[LEAVES + w] = '1;
      end
      node_way[LEAVES + w] = WAY_BITS'(w);
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (node_key[2*i + 1] < node_key[2*i]) begin
        node_key[i] = node_key[2*i + 1];
        node_way[i] = node_way[2*i + 1];
      end else begin
        node_key[i] = node_key[2*i];
        node_way[i] = node_way[2*i];
      end
    end
  end

  // single-way update of the row
  assign wr_hit  = (item.req_type != REQ_QUERY) && (int'(item.way_index) < NUM_WAYS);
  assign wr_time = (item.req_type == REQ_INVALIDATE) ? '0 : TIME_BITS'(item.current_time);

  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (int'(item.way_index) == w) begin
        new_row[w*TIME_BITS +: TIME_BITS] = wr_time;
      end
    end
  end

  always_comb begin
    result = '0;
    if (item.req_type == REQ_QUERY) begin
      result.victim_valid = 1'b1;
      result.victim_way   = WAY_FIELD_W'(node_way[1]);
      result.victim_dirty = node_key[1][KEY_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_done) begin
      out_data <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
